// ----- hdl/gwbs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwbs_pkg - shared types and constants for the grid boundary segment block
// Field widths, register indexes, side codes and inter-module structs.
// ----------------------------------------------------------------------------
package gwbs_pkg;

  localparam int ROW_LEN_W = 11;
  localparam int CELL_W    = 8;
  localparam int COORD_W   = 18;
  localparam int SIDE_W    = 2;
  localparam int NUM_SIDES = 4;

  // configuration register indexes
  localparam logic REG_ROW_LENGTH = 1'b0;
  localparam logic REG_CELL_SIZE  = 1'b1;

  localparam logic [ROW_LEN_W-1:0] ROW_LENGTH_RST = 11'd1024;
  localparam logic [CELL_W-1:0]    CELL_SIZE_RST  = 8'd40;

  // edge of the wall cell
  localparam logic [SIDE_W-1:0] SIDE_TOP    = 2'd0;
  localparam logic [SIDE_W-1:0] SIDE_BOTTOM = 2'd1;
  localparam logic [SIDE_W-1:0] SIDE_LEFT   = 2'd2;
  localparam logic [SIDE_W-1:0] SIDE_RIGHT  = 2'd3;

  // read data of the row buffers for one column
  typedef struct packed {
    logic up_cur;     // row r-1 at column c
    logic mid_cur;    // row r at column c
    logic mid_right;  // row r at column c+1
  } row_rd_t;

  // one wall cell handed to the segment emitter
  typedef struct packed {
    logic [NUM_SIDES-1:0] mask;  // bit index = side code
    logic [COORD_W-1:0]   x0;
    logic [COORD_W-1:0]   x1;
    logic [COORD_W-1:0]   y0;
    logic [COORD_W-1:0]   y1;
  } seg_load_t;

endpackage

// ----- hdl/gwbs_row_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwbs_row_store - the two one-bit row buffers
// Upper row: one read, one write. Middle row: two reads, one write.
// Registered reads, write-first on an address match.
// ----------------------------------------------------------------------------
module gwbs_row_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic              clk,
  input  logic              rd_en,
  input  logic [AW-1:0]     rd_addr,
  input  logic [AW-1:0]     rd_addr_right,
  input  logic              we,
  input  logic [AW-1:0]     wr_addr,
  input  logic              wr_upper,
  input  logic              wr_middle,
  output gwbs_pkg::row_rd_t rd
);

  logic upper_mem  [DEPTH];
  logic middle_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      upper_mem[wr_addr]  <= wr_upper;
      middle_mem[wr_addr] <= wr_middle;
    end
    if (rd_en) begin
      rd.up_cur    <= (we && wr_addr == rd_addr) ? wr_upper : upper_mem[rd_addr];
      rd.mid_cur   <= (we && wr_addr == rd_addr) ? wr_middle : middle_mem[rd_addr];
      rd.mid_right <= (we && wr_addr == rd_addr_right) ? wr_middle
                                                       : middle_mem[rd_addr_right];
    end
  end

endmodule

// ----- hdl/gwbs_seg_emit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gwbs_seg_emit - segment emitter and output register
// Holds one wall cell and sends its segments, one per cycle unless the output stalls, top first.
// ----------------------------------------------------------------------------
module gwbs_seg_emit (
  input  logic                clk,
  input  logic                rst,
  input  logic                load_valid,
  input  gwbs_pkg::seg_load_t load,
  output logic                load_ready,
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [79:0]         m_tdata,  // x_start, y_start, x_end, y_end, side, zero pad
  output logic                m_tlast   // last_of_run
);

  logic [gwbs_pkg::NUM_SIDES-1:0] mask;
  logic [gwbs_pkg::NUM_SIDES-1:0] mask_after;
  logic [gwbs_pkg::COORD_W-1:0]   x0, x1, y0, y1;
  logic [gwbs_pkg::COORD_W-1:0]   x_start, y_start, x_end, y_end;
  logic [gwbs_pkg::COORD_W-1:0]   xs_sel, ys_sel, xe_sel, ye_sel;
  logic [gwbs_pkg::SIDE_W-1:0]    side, sel_side;
  logic                           emit;

  assign emit = (mask != '0) && (!m_tvalid || m_tready);

  always_comb begin
    if (mask[gwbs_pkg::SIDE_TOP])         sel_side = gwbs_pkg::SIDE_TOP;
    else if (mask[gwbs_pkg::SIDE_BOTTOM]) sel_side = gwbs_pkg::SIDE_BOTTOM;
    else if (mask[gwbs_pkg::SIDE_LEFT])   sel_side = gwbs_pkg::SIDE_LEFT;
    else                                  sel_side = gwbs_pkg::SIDE_RIGHT;
  end

  assign mask_after = mask & ~(gwbs_pkg::NUM_SIDES'(1) << sel_side);
  assign load_ready = (mask == '0) || (emit && mask_after == '0);

  always_comb begin
    case (sel_side)
      gwbs_pkg::SIDE_TOP: begin
        xs_sel = x0; ys_sel = y0; xe_sel = x1; ye_sel = y0;
      end
      gwbs_pkg::SIDE_BOTTOM: begin
        xs_sel = x0; ys_sel = y1; xe_sel = x1; ye_sel = y1;
      end
      gwbs_pkg::SIDE_LEFT: begin
        xs_sel = x0; ys_sel = y0; xe_sel = x0; ye_sel = y1;
      end
      default: begin
        xs_sel = x1; ys_sel = y0; xe_sel = x1; ye_sel = y1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mask     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (!m_tvalid || m_tready) begin
        m_tvalid <= emit;
      end
      if (load_valid && load_ready) begin
        mask <= load.mask;
      end else if (emit) begin
        mask <= mask_after;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      x0 <= load.x0;
      x1 <= load.x1;
      y0 <= load.y0;
      y1 <= load.y1;
    end
    if (emit) begin
      x_start <= xs_sel;
      y_start <= ys_sel;
      x_end   <= xe_sel;
      y_end   <= ye_sel;
      side    <= sel_side;
      m_tlast <= (mask_after == '0);
    end
  end

  assign m_tdata = {6'd0, side, y_end, x_end, y_start, x_start};

endmodule

// ----- hdl/grid_wall_boundary_segments.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_wall_boundary_segments - boundary segments of a binary wall grid
// Takes grid cells in raster order and emits the wall edges that face open
// cells, one row behind the input.
// ----------------------------------------------------------------------------
// Each input item is one grid cell (tuser = 0, tdata bit 0 = open) or a drain
// item (tuser = 1) that closes the last row. Output runs one row behind: the
// item at column c of row r+1 releases the cell at column c of row r, and a
// wall cell there yields one segment per open neighbour, top, bottom, left,
// right in that order, tlast on the last one. The emitter holds one cell; an
// item with at most one segment does not hold up the next unless the output
// stalls, else the input waits until its last segment (of up to four) is sent.
// The first segment passes the read-data stage, the emitter's mask register
// and the output register. After reset and after a drain item ending a row,
// all MAX_WIDTH row buffer columns are swept to walls, one per cycle while
// the read-data stage is empty, and only configuration writes are taken.
// ----------------------------------------------------------------------------
module grid_wall_boundary_segments #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  logic        clk,
  input  logic        rst,
  // input items
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // open, zero pad
  input  logic [0:0]  s_tuser,   // func
  // result items
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [79:0] m_tdata,   // x_start, y_start, x_end, y_end, side, zero pad
  output logic        m_tlast,   // last_of_run
  // configuration
  input  logic        cfg_we,
  input  logic [0:0]  cfg_addr,
  input  logic [10:0] cfg_wdata
);

  localparam int CW = $clog2(MAX_WIDTH);       // column index
  localparam int LW = $clog2(MAX_WIDTH + 1);   // effective row length
  localparam int RW = $clog2(MAX_HEIGHT + 1);  // row count

  // configuration registers
  logic [gwbs_pkg::ROW_LEN_W-1:0] row_length;
  logic [gwbs_pkg::CELL_W-1:0]    tile_size;

  // scan position
  logic [CW-1:0] column_count;
  logic [RW-1:0] row_count;
  logic          row_pending;
  logic          left_cell;

  // clearing sweep
  logic          clearing;
  logic [CW-1:0] clr_addr;
  logic          sweep_we;

  // accept stage
  logic          accept;
  logic          drain, below;
  logic [LW-1:0] len;
  logic [CW-1:0] at_c, rd_right;
  logic          last_col;

  // read-data stage: one item waiting on the row buffer data
  logic          b_valid;
  logic [CW-1:0] b_c;
  logic [RW-1:0] b_r;
  logic          b_pending, b_below, b_left, b_left_ok, b_right_ok;
  logic          b_done;
  logic          cur;
  logic [31:0]   x0_full, y0_full;

  gwbs_pkg::row_rd_t   rd;
  gwbs_pkg::seg_load_t load;
  logic                load_ready;

  // row buffer write port
  logic          mem_we;
  logic [CW-1:0] mem_wa;

  // --------------------------------------------------------------------------
  // configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      row_length <= gwbs_pkg::ROW_LENGTH_RST;
      tile_size  <= gwbs_pkg::CELL_SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_addr)
        gwbs_pkg::REG_ROW_LENGTH: row_length <= cfg_wdata;
        gwbs_pkg::REG_CELL_SIZE:  tile_size  <= cfg_wdata[gwbs_pkg::CELL_W-1:0];
        default: ;
      endcase
    end
  end

  // effective length: zero reads as one, clipped to the buffer depth
  always_comb begin
    if (row_length == '0)                       len = LW'(1);
    else if (32'(row_length) > 32'(MAX_WIDTH))  len = LW'(MAX_WIDTH);
    else                                        len = LW'(row_length);
  end

  // column in use; a shortened row ends at its new last column
  assign at_c     = (LW'(column_count) >= len) ? CW'(len - LW'(1)) : column_count;
  assign last_col = (LW'(at_c) == len - LW'(1));
  assign rd_right = last_col ? at_c : at_c + CW'(1);

  assign drain    = s_tuser[0];
  assign below    = !drain && s_tdata[0];

  // --------------------------------------------------------------------------
  // handshake: a new item enters when no sweep runs and the read-data stage is empty or moving
  // --------------------------------------------------------------------------
  assign b_done   = b_valid && load_ready;
  assign s_tready = !clearing && (!b_valid || b_done);
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
      row_pending  <= 1'b0;
      clearing     <= 1'b1;
      clr_addr     <= '0;
    end else begin
      if (accept) begin
        if (last_col) begin
          column_count <= '0;
          if (drain) begin
            // grid complete: back to the start state
            row_count   <= '0;
            row_pending <= 1'b0;
            clearing    <= 1'b1;
            clr_addr    <= '0;
          end else begin
            row_pending <= 1'b1;
            if (row_count != RW'(MAX_HEIGHT)) row_count <= row_count + RW'(1);
          end
        end else begin
          column_count <= at_c + CW'(1);
        end
      end else if (sweep_we) begin
        if (clr_addr == CW'(MAX_WIDTH - 1)) clearing <= 1'b0;
        else                                clr_addr <= clr_addr + CW'(1);
      end
    end
  end

  // --------------------------------------------------------------------------
  // read-data stage
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (accept) begin
      b_valid <= 1'b1;
    end else if (b_done) begin
      b_valid <= 1'b0;
    end
  end

  assign cur = rd.mid_cur;

  // the left neighbour is the previous item's centre cell
  always_ff @(posedge clk) begin
    if (b_done) left_cell <= cur;
    if (accept) begin
      b_c        <= at_c;
      b_r        <= row_count - RW'(1);
      b_pending  <= row_pending;
      b_below    <= below;
      b_left     <= b_valid ? cur : left_cell;
      b_left_ok  <= (at_c != '0);
      b_right_ok <= !last_col;
    end
  end

  assign x0_full = 32'(b_c) * 32'(tile_size);
  assign y0_full = 32'(b_r) * 32'(tile_size);

  always_comb begin
    load.mask = '0;
    if (b_pending && !cur) begin
      load.mask[gwbs_pkg::SIDE_TOP]    = rd.up_cur;
      load.mask[gwbs_pkg::SIDE_BOTTOM] = b_below;
      load.mask[gwbs_pkg::SIDE_LEFT]   = b_left_ok && b_left;
      load.mask[gwbs_pkg::SIDE_RIGHT]  = b_right_ok && rd.mid_right;
    end
    load.x0 = x0_full[gwbs_pkg::COORD_W-1:0];
    load.y0 = y0_full[gwbs_pkg::COORD_W-1:0];
    load.x1 = gwbs_pkg::COORD_W'(x0_full + 32'(tile_size));
    load.y1 = gwbs_pkg::COORD_W'(y0_full + 32'(tile_size));
  end

  // --------------------------------------------------------------------------
  // row buffers: the item leaving the read-data stage writes back, the sweep
  // takes the port only when that stage is empty
  // --------------------------------------------------------------------------
  assign sweep_we = clearing && !b_valid;
  assign mem_we   = b_done || sweep_we;
  assign mem_wa   = b_done ? b_c : clr_addr;

  gwbs_row_store #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_row_store (
    .clk           (clk),
    .rd_en         (accept),
    .rd_addr       (at_c),
    .rd_addr_right (rd_right),
    .we            (mem_we),
    .wr_addr       (mem_wa),
    .wr_upper      (b_done && cur),
    .wr_middle     (b_done && b_below),
    .rd            (rd)
  );

  gwbs_seg_emit u_seg_emit (
    .clk        (clk),
    .rst        (rst),
    .load_valid (b_valid),
    .load       (load),
    .load_ready (load_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tlast    (m_tlast)
  );

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !s_tready)
    else $error("item accepted during clearing sweep");

  a_sweep_after_drain: assert property (@(posedge clk) disable iff (rst)
    sweep_we |-> !b_valid && !b_done)
    else $error("sweep write collides with item write-back");

  a_item_held: assert property (@(posedge clk) disable iff (rst)
    b_valid && !b_done |=> b_valid && $stable(b_c) && $stable(b_below))
    else $error("waiting item lost before hand-off to emitter");

  a_single_writer: assert property (@(posedge clk) disable iff (rst)
    accept && b_valid |-> b_done)
    else $error("new item overwrote an item still in the read-data stage");

endmodule
